// ----- hw/rtl/dmxu_pkg.sv -----
// ----------------------------------------------------------------------------
// dmxu_pkg - shared types and constants of the DMX-over-UDP packet parser
// Beat layouts, header offsets, protocol signatures and the slot clamp.
// ----------------------------------------------------------------------------
package dmxu_pkg;

  // Slot store limit (DMX universe size)
  localparam logic [9:0]  MAX_SLOTS       = 10'd512;
  localparam logic [9:0]  OFFSET_MAX      = 10'd1023;

  // Art-Net header layout
  localparam logic [9:0]  ART_SIG_LEN     = 10'd8;
  localparam logic [9:0]  ART_OPC_LO      = 10'd8;
  localparam logic [9:0]  ART_OPC_HI      = 10'd9;
  localparam logic [9:0]  ART_UNI_LO      = 10'd14;
  localparam logic [9:0]  ART_UNI_HI      = 10'd15;
  localparam logic [9:0]  ART_LEN_HI      = 10'd16;
  localparam logic [9:0]  ART_LEN_LO      = 10'd17;
  localparam logic [9:0]  ART_DATA_START  = 10'd18;
  localparam logic [15:0] ART_OPDMX       = 16'h5000;

  // sACN E1.31 header layout
  localparam logic [9:0]  SACN_SIG_START  = 10'd4;
  localparam logic [9:0]  SACN_SIG_END    = 10'd13;
  localparam logic [9:0]  SACN_UNI_HI     = 10'd113;
  localparam logic [9:0]  SACN_UNI_LO     = 10'd114;
  localparam logic [9:0]  SACN_CNT_HI     = 10'd123;
  localparam logic [9:0]  SACN_CNT_LO     = 10'd124;
  localparam logic [9:0]  SACN_DATA_START = 10'd126;

  // Protocol tag carried on tuser
  localparam logic        FUNC_ARTNET     = 1'b0;
  localparam logic        FUNC_SACN       = 1'b1;

  // Register map (word index)
  localparam logic        REG_UNIVERSE    = 1'b0;

  localparam int          OUT_TDATA_W     = 88;

  typedef struct packed {
    logic       func;
    logic [7:0] payload_byte;
    logic       last_byte;
  } dmxu_item_t;

  typedef struct packed {
    logic        slot_write;
    logic [8:0]  slot_index;
    logic [7:0]  slot_value;
    logic        slot_store;
    logic        packet_done;
    logic        packet_accepted;
    logic [31:0] art_packets;
    logic [31:0] sacn_packets;
  } dmxu_result_t;

  // "Art-Net\0"
  function automatic logic [7:0] art_sig(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h2D;
      3'd4:    c = 8'h4E;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "ASC-E1.17"
  function automatic logic [7:0] sacn_sig(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h41;
      4'd1:    c = 8'h53;
      4'd2:    c = 8'h43;
      4'd3:    c = 8'h2D;
      4'd4:    c = 8'h45;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h31;
      4'd8:    c = 8'h37;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [9:0] clamp_slots(input logic [15:0] n);
    return (n > {6'd0, MAX_SLOTS}) ? MAX_SLOTS : n[9:0];
  endfunction

endpackage

// ----- hw/rtl/dmxu_cfg.sv -----
// ----------------------------------------------------------------------------
// dmxu_cfg - APB register block
// Holds the universe match register; pready is tied high.
// ----------------------------------------------------------------------------
module dmxu_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] universe
);

  logic [15:0] universe_r;
  logic [15:0] universe_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    universe_nxt = universe_r;
    if (wr_en && paddr[2] == dmxu_pkg::REG_UNIVERSE) begin
      universe_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      universe_r <= '0;
    end else begin
      universe_r <= universe_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      dmxu_pkg::REG_UNIVERSE: prdata = {16'd0, universe_r};
      default:                prdata = '0;
    endcase
  end

  assign universe = universe_r;

endmodule

// ----- hw/rtl/dmxu_in_reg.sv -----
// ----------------------------------------------------------------------------
// dmxu_in_reg - input beat register
// Registers one payload beat; frees itself when the parser consumes it.
// ----------------------------------------------------------------------------
module dmxu_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmxu_pkg::dmxu_item_t in_item,
  input  logic                 consume,
  output logic                 item_valid,
  output dmxu_pkg::dmxu_item_t item
);

  logic                 valid_r;
  logic                 valid_nxt;
  dmxu_pkg::dmxu_item_t item_r;
  logic                 load;

  assign in_ready = !valid_r || consume;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- hw/rtl/dmxu_parse.sv -----
// ----------------------------------------------------------------------------
// dmxu_parse - per-packet header checker and slot writer
// Holds offset, captures and packet counters; builds one result per beat.
// ----------------------------------------------------------------------------
module dmxu_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  dmxu_pkg::dmxu_item_t   item,
  input  logic [15:0]            universe,
  output dmxu_pkg::dmxu_result_t result
);

  logic [9:0]  off_r,  off_nxt;
  logic        hdr_r,  hdr_nxt;
  logic [15:0] opc_r,  opc_nxt;
  logic [15:0] uni_r,  uni_nxt;
  logic [15:0] len_r,  len_nxt;
  logic [31:0] art_r,  art_nxt;
  logic [31:0] sacn_r, sacn_nxt;

  logic        hdr_cur;
  logic [15:0] opc_cur, uni_cur, len_cur, len_m1;
  logic [9:0]  art_idx, sacn_idx, sacn_sig_off;
  logic [7:0]  b;
  logic        pass, wr, acc;
  logic [9:0]  idx;

  assign b            = item.payload_byte;
  assign art_idx      = off_r - dmxu_pkg::ART_DATA_START;
  assign sacn_idx     = off_r - dmxu_pkg::SACN_DATA_START;
  assign sacn_sig_off = off_r - dmxu_pkg::SACN_SIG_START;
  assign len_m1       = len_cur - 16'd1;

  // Captures including this beat; the checks below see them at once
  always_comb begin
    hdr_cur = hdr_r;
    opc_cur = opc_r;
    uni_cur = uni_r;
    len_cur = len_r;
    pass    = 1'b0;
    wr      = 1'b0;
    acc     = 1'b0;
    idx     = '0;
    if (item.func == dmxu_pkg::FUNC_ARTNET) begin
      if (off_r < dmxu_pkg::ART_SIG_LEN && b != dmxu_pkg::art_sig(off_r[2:0])) begin
        hdr_cur = 1'b0;
      end
      if (off_r == dmxu_pkg::ART_OPC_LO) opc_cur[7:0]  = b;
      if (off_r == dmxu_pkg::ART_OPC_HI) opc_cur[15:8] = b;
      if (off_r == dmxu_pkg::ART_UNI_LO) uni_cur[7:0]  = b;
      if (off_r == dmxu_pkg::ART_UNI_HI) uni_cur[15:8] = b;
      if (off_r == dmxu_pkg::ART_LEN_HI) len_cur[15:8] = b;
      if (off_r == dmxu_pkg::ART_LEN_LO) len_cur[7:0]  = b;
      pass = hdr_cur && opc_cur == dmxu_pkg::ART_OPDMX && uni_cur == universe;
      idx  = art_idx;
      wr   = pass && off_r >= dmxu_pkg::ART_DATA_START &&
             art_idx < dmxu_pkg::clamp_slots(len_cur);
      // packet must reach the low length byte
      acc  = item.last_byte && pass && off_r >= dmxu_pkg::ART_LEN_LO;
    end else begin
      if (off_r >= dmxu_pkg::SACN_SIG_START && off_r < dmxu_pkg::SACN_SIG_END &&
          b != dmxu_pkg::sacn_sig(sacn_sig_off[3:0])) begin
        hdr_cur = 1'b0;
      end
      if (off_r == dmxu_pkg::SACN_UNI_HI) uni_cur[15:8] = b;
      if (off_r == dmxu_pkg::SACN_UNI_LO) uni_cur[7:0]  = b;
      if (off_r == dmxu_pkg::SACN_CNT_HI) len_cur[15:8] = b;
      if (off_r == dmxu_pkg::SACN_CNT_LO) len_cur[7:0]  = b;
      pass = hdr_cur && uni_cur == universe && len_cur != 16'd0;
      idx  = sacn_idx;
      // property count includes the start code
      wr   = pass && off_r >= dmxu_pkg::SACN_DATA_START &&
             sacn_idx < dmxu_pkg::clamp_slots(len_m1);
      acc  = item.last_byte && pass &&
             off_r >= (dmxu_pkg::SACN_DATA_START - 10'd1);
    end
  end

  always_comb begin
    art_nxt  = art_r;
    sacn_nxt = sacn_r;
    if (acc && item.func == dmxu_pkg::FUNC_ARTNET) art_nxt  = art_r + 32'd1;
    if (acc && item.func == dmxu_pkg::FUNC_SACN)   sacn_nxt = sacn_r + 32'd1;
    if (item.last_byte) begin
      off_nxt = '0;
      hdr_nxt = 1'b1;
      opc_nxt = '0;
      uni_nxt = '0;
      len_nxt = '0;
    end else begin
      off_nxt = (off_r < dmxu_pkg::OFFSET_MAX) ? off_r + 10'd1 : off_r;
      hdr_nxt = hdr_cur;
      opc_nxt = opc_cur;
      uni_nxt = uni_cur;
      len_nxt = len_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      hdr_r  <= 1'b1;
      opc_r  <= '0;
      uni_r  <= '0;
      len_r  <= '0;
      art_r  <= '0;
      sacn_r <= '0;
    end else if (fire) begin
      off_r  <= off_nxt;
      hdr_r  <= hdr_nxt;
      opc_r  <= opc_nxt;
      uni_r  <= uni_nxt;
      len_r  <= len_nxt;
      art_r  <= art_nxt;
      sacn_r <= sacn_nxt;
    end
  end

  always_comb begin
    result.slot_write      = wr;
    result.slot_index      = wr ? idx[8:0] : 9'd0;
    result.slot_value      = wr ? b : 8'd0;
    result.slot_store      = item.func;
    result.packet_done     = item.last_byte;
    result.packet_accepted = acc;
    result.art_packets     = art_nxt;
    result.sacn_packets    = sacn_nxt;
  end

endmodule

// ----- hw/rtl/dmxu_out_reg.sv -----
// ----------------------------------------------------------------------------
// dmxu_out_reg - result beat register
// Holds one result until the sink takes it; reports room for the next.
// ----------------------------------------------------------------------------
module dmxu_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  dmxu_pkg::dmxu_result_t result,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dmxu_pkg::dmxu_result_t out_result
);

  logic                   valid_r;
  logic                   valid_nxt;
  dmxu_pkg::dmxu_result_t result_r;

  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ----- hw/rtl/dmx_over_udp_packet_parser.sv -----
// ----------------------------------------------------------------------------
// dmx_over_udp_packet_parser - Art-Net / sACN E1.31 DMX receiver
// Parses UDP payload beats and emits one slot-write result beat per byte.
// ----------------------------------------------------------------------------
// Feed the UDP payload one byte per beat with in_tuser giving the protocol
// (0 Art-Net, 1 sACN) and in_tlast on the final byte; every input beat gives
// exactly one output beat, in order. Each beat is registered in the input
// register, then the header check, capture and slot decision settle into
// the result register; a new byte can enter every cycle while out_tready
// is high. Art-Net packets need the "Art-Net" signature, opcode 0x5000 and a
// matching universe; data bytes from offset 18 become slots 0.. up to the
// clamped length. sACN packets need the "ASC-E1.17" identifier, a matching
// universe and a nonzero property count; data from offset 126 become the
// first count-1 slots, clamped to 512. The universe register sits at byte
// address 0 of the APB port and should only be written while no packet is in
// flight. out_tlast marks the last byte's result, where packet_accepted tells
// whether the packet passed; the running accepted-packet counters ride on
// every result beat.
module dmx_over_udp_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  // payload beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tuser,   // [0] func
  input  logic        in_tlast,   // last_byte
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] slot_write, [9:1] slot_index, [17:10] slot_value, [18] packet_accepted,
  // [50:19] art_packets, [82:51] sacn_packets, [87:83] zero
  output logic [dmxu_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic        out_tuser,  // [0] slot_store
  output logic        out_tlast,  // packet_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dmxu_pkg::dmxu_item_t   in_item;
  dmxu_pkg::dmxu_item_t   item;
  dmxu_pkg::dmxu_result_t result;
  dmxu_pkg::dmxu_result_t out_result;
  logic                   item_valid;
  logic                   out_space;
  logic                   fire;
  logic [15:0]            universe;

  assign in_item.func         = in_tuser;
  assign in_item.payload_byte = in_tdata;
  assign in_item.last_byte    = in_tlast;

  // a beat moves through the parser when the result register has room
  assign fire = item_valid && out_space;

  dmxu_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .universe (universe)
  );

  dmxu_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .consume    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  dmxu_parse u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (item),
    .universe (universe),
    .result   (result)
  );

  dmxu_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .space      (out_space),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {5'd0,
                      out_result.sacn_packets,
                      out_result.art_packets,
                      out_result.packet_accepted,
                      out_result.slot_value,
                      out_result.slot_index,
                      out_result.slot_write};
  assign out_tuser = out_result.slot_store;
  assign out_tlast = out_result.packet_done;

endmodule

// ----- hw/rtl/dmxu_checker.sv -----
// ----------------------------------------------------------------------------
// dmxu_checker - port-level assertions for the packet parser
// Bound to the top level; watches the result channel only.
// ----------------------------------------------------------------------------
module dmxu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dmxu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                              out_tlast
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // acceptance is only reported on the last byte of a packet
  a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18] |-> out_tlast)
    else $error("packet_accepted without packet_done");

  // no slot write: index and value read zero
  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[17:1] == 17'd0)
    else $error("slot fields nonzero without slot_write");

  // nothing is presented straight out of reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dmx_over_udp_packet_parser dmxu_checker u_dmxu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
